FILE: hdl/djf_pkg.sv
package djf_pkg;

  localparam int QUEUE_DEPTH  = 32;
  localparam int SERIES_WIDTH = 32;

  // port field widths
  localparam int SERIES_BITS = 32;
  localparam int DAY_BITS    = 16;
  localparam int STATUS_BITS = 3;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  // bits of a series id actually kept and compared
  localparam int SER_KEEP_W = (SERIES_WIDTH < SERIES_BITS) ? SERIES_WIDTH : SERIES_BITS;

  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 64;

  localparam logic [DAY_BITS-1:0] WINDOW_SPAN = 16'd13;

  localparam logic [STATUS_BITS-1:0] ST_ENQUEUED  = 3'd0;
  localparam logic [STATUS_BITS-1:0] ST_DUPLICATE = 3'd1;
  localparam logic [STATUS_BITS-1:0] ST_FULL      = 3'd2;
  localparam logic [STATUS_BITS-1:0] ST_DEQUEUED  = 3'd3;
  localparam logic [STATUS_BITS-1:0] ST_EMPTY     = 3'd4;

  localparam logic FUNC_ENQ = 1'b0;
  localparam logic FUNC_DEQ = 1'b1;

  typedef struct packed {
    logic cap;     // latch request and register the compare vector
    logic commit;  // resolve request, update ring, load result register
  } djf_cmd_t;

  typedef struct packed {
    logic out_busy;  // result register holds a transfer not taken this cycle
    logic full;
    logic empty;
  } djf_stat_t;

endpackage

FILE: hdl/dedup_job_fifo.sv
// channel | direction | tdata (low bit up)                      | tuser
// in_     | slave     | series_id[31:0], start_day[47:32]       | func (0 enq, 1 deq)
// out_    | master    | out_series[31:0], out_begin[47:32],     | status[2:0]
//         |           | out_end[63:48]                          |
//
// Requests are taken one at a time: the per-slot duplicate compare over all 32
// ring slots is registered, then the request is resolved and the ring updated.
// A request is held in the resolve cycle while the result register is stalled.
// Reset empties the ring (pointers and count); slot contents are not cleared.
module dedup_job_fifo (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [djf_pkg::IN_DATA_W-1:0]     in_tdata,   // series_id, start_day
  input  logic                              in_tuser,   // func
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [djf_pkg::OUT_DATA_W-1:0]    out_tdata,  // out_series, out_begin, out_end
  output logic [djf_pkg::STATUS_BITS-1:0]   out_tuser   // status
);
  import djf_pkg::*;

  djf_cmd_t  cmd;
  djf_stat_t stat;

  logic [SERIES_BITS-1:0] o_series;
  logic [DAY_BITS-1:0]    o_begin, o_end;

  djf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  djf_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_func    (in_tuser),
    .in_series  (in_tdata[31:0]),
    .in_start   (in_tdata[47:32]),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_status (out_tuser),
    .out_series (o_series),
    .out_begin  (o_begin),
    .out_end    (o_end)
  );

  assign out_tdata = {o_end, o_begin, o_series};

`ifndef NO_ASSERTIONS
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("request accepted while another is in flight");

  a_result_from_commit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(cmd.commit))
    else $error("result transfer without commit");

  a_full_empty_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(stat.full && stat.empty))
    else $error("ring both full and empty");

  a_no_commit_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> !(out_tvalid && !out_tready))
    else $error("commit overwrote a pending result");
`endif

endmodule

FILE: hdl/djf_ctrl.sv
module djf_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  djf_pkg::djf_stat_t stat,
  output djf_pkg::djf_cmd_t  cmd
);
  import djf_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_RES  = 1'b1;

  logic state_r, state_nxt;

  always_comb begin
    state_nxt  = state_r;
    in_tready  = 1'b0;
    cmd        = '0;
    unique case (state_r)
      S_IDLE: begin
        // no transfer is taken while reset is held
        in_tready = rst_n;
        if (in_tvalid) begin
          cmd.cap   = 1'b1;
          state_nxt = S_RES;
        end
      end
      S_RES: begin
        // hold until the result register can take the new transfer
        if (!stat.out_busy) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: hdl/djf_dp.sv
module djf_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  djf_pkg::djf_cmd_t                   cmd,
  output djf_pkg::djf_stat_t                  stat,
  input  logic                                in_func,
  input  logic [djf_pkg::SERIES_BITS-1:0]     in_series,
  input  logic [djf_pkg::DAY_BITS-1:0]        in_start,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [djf_pkg::STATUS_BITS-1:0]     out_status,
  output logic [djf_pkg::SERIES_BITS-1:0]     out_series,
  output logic [djf_pkg::DAY_BITS-1:0]        out_begin,
  output logic [djf_pkg::DAY_BITS-1:0]        out_end
);
  import djf_pkg::*;

  function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // job store, undefined until written
  logic [SER_KEEP_W-1:0] job_series_r [QUEUE_DEPTH];
  logic [DAY_BITS-1:0]   job_begin_r  [QUEUE_DEPTH];

  logic [PTR_W-1:0] head_r, tail_r;
  logic [CNT_W-1:0] fill_r;

  logic                  func_r;
  logic [SER_KEEP_W-1:0] ser_r;
  logic [DAY_BITS-1:0]   beg_r;
  logic [QUEUE_DEPTH-1:0] match_r;

  logic                   out_valid_r;
  logic [STATUS_BITS-1:0] status_r;
  logic [SERIES_BITS-1:0] oser_r;
  logic [DAY_BITS-1:0]    obeg_r, oend_r;

  logic [SER_KEEP_W-1:0] in_ser_keep;
  logic full, empty, dup;
  logic do_enq, do_deq;
  logic [STATUS_BITS-1:0] status_nxt;
  logic [SER_KEEP_W-1:0]  head_ser;
  logic [DAY_BITS-1:0]    head_beg;

  assign in_ser_keep = in_series[SER_KEEP_W-1:0];
  assign full  = (fill_r == CNT_W'(QUEUE_DEPTH));
  assign empty = (fill_r == '0);
  assign dup   = |match_r;
  assign head_ser = job_series_r[head_r];
  assign head_beg = job_begin_r[head_r];

  // per-slot compare against the incoming job, masked by ring occupancy
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cmp
    localparam logic [PTR_W:0] IDX = (PTR_W+1)'(i);
    logic [PTR_W:0] off;
    logic           occ;
    assign off = IDX + ((IDX < {1'b0, head_r}) ? (PTR_W+1)'(QUEUE_DEPTH) : '0)
                 - {1'b0, head_r};
    assign occ = (off < (PTR_W+1)'(fill_r));
    always_ff @(posedge clk) begin
      if (cmd.cap) begin
        match_r[i] <= occ && (job_series_r[i] == in_ser_keep) && (job_begin_r[i] == in_start);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      func_r <= in_func;
      ser_r  <= in_ser_keep;
      beg_r  <= in_start;
    end
  end

  always_comb begin
    do_enq = 1'b0;
    do_deq = 1'b0;
    if (func_r == FUNC_ENQ) begin
      if (full) begin
        status_nxt = ST_FULL;
      end else if (dup) begin
        status_nxt = ST_DUPLICATE;
      end else begin
        status_nxt = ST_ENQUEUED;
        do_enq     = 1'b1;
      end
    end else begin
      if (empty) begin
        status_nxt = ST_EMPTY;
      end else begin
        status_nxt = ST_DEQUEUED;
        do_deq     = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && do_enq) begin
      job_series_r[tail_r] <= ser_r;
      job_begin_r[tail_r]  <= beg_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      fill_r <= '0;
    end else if (cmd.commit) begin
      if (do_enq) begin
        tail_r <= next_slot(tail_r);
        fill_r <= fill_r + 1'b1;
      end
      if (do_deq) begin
        head_r <= next_slot(head_r);
        fill_r <= fill_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      status_r <= status_nxt;
      oser_r   <= do_deq ? SERIES_BITS'(head_ser) : '0;
      obeg_r   <= do_deq ? head_beg : '0;
      oend_r   <= do_deq ? head_beg + WINDOW_SPAN : '0;
    end
  end

  assign stat.out_busy = out_valid_r && !out_ready;
  assign stat.full     = full;
  assign stat.empty    = empty;

  assign out_valid  = out_valid_r;
  assign out_status = status_r;
  assign out_series = oser_r;
  assign out_begin  = obeg_r;
  assign out_end    = oend_r;

endmodule

FILE: verif/job_fifo_checker.sv
`timescale 1ns / 100ps

module job_fifo_checker
  import djf_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [IN_DATA_W-1:0]   in_tdata,   // series_id, start_day
  input  logic                   in_tuser,   // func
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [OUT_DATA_W-1:0]  out_tdata,  // out_series, out_begin, out_end
  input  logic [STATUS_BITS-1:0] out_tuser,  // status
  output int                     errors,
  output int                     due_count
);

  typedef struct packed {
    logic [STATUS_BITS-1:0] status;
    logic [SERIES_BITS-1:0] series;
    logic [DAY_BITS-1:0]    win_begin;
    logic [DAY_BITS-1:0]    win_end;
  } job_reply_t;

  localparam logic [SERIES_BITS-1:0] KEEP_MASK =
    {SERIES_BITS{1'b1}} >> (SERIES_BITS - SER_KEEP_W);

  // shadow ring of queued jobs
  logic [SERIES_BITS-1:0] ring_series [QUEUE_DEPTH];
  logic [DAY_BITS-1:0]    ring_day    [QUEUE_DEPTH];
  logic [PTR_W-1:0]       head_slot;
  logic [PTR_W-1:0]       tail_slot;
  logic [CNT_W-1:0]       jobs_held;

  job_reply_t pending_replies[$];
  int         reply_no;

  initial begin
    errors    = 0;
    due_count = 0;
    reply_no  = 0;
  end

  function automatic logic [PTR_W-1:0] slot_after(logic [PTR_W-1:0] p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // applies one request to the shadow ring and returns the reply it must produce
  function automatic job_reply_t apply_job_request(logic func, logic [SERIES_BITS-1:0] ser_in,
                                                   logic [DAY_BITS-1:0] day);
    job_reply_t             r;
    logic [SERIES_BITS-1:0] ser;
    logic [PTR_W-1:0]       p;
    logic                   hit;
    int                     k;
    r   = '0;
    ser = ser_in & KEEP_MASK;
    if (func == FUNC_ENQ) begin
      // full wins over duplicate
      if (jobs_held == CNT_W'(QUEUE_DEPTH)) begin
        r.status = ST_FULL;
      end else begin
        hit = 1'b0;
        p   = head_slot;
        for (k = 0; k < jobs_held; k++) begin
          if (ring_series[p] == ser && ring_day[p] == day) hit = 1'b1;
          p = slot_after(p);
        end
        if (hit) begin
          r.status = ST_DUPLICATE;
        end else begin
          ring_series[tail_slot] = ser;
          ring_day[tail_slot]    = day;
          tail_slot = slot_after(tail_slot);
          jobs_held = jobs_held + 1'b1;
          r.status  = ST_ENQUEUED;
        end
      end
    end else begin
      if (jobs_held == '0) begin
        r.status = ST_EMPTY;
      end else begin
        r.status    = ST_DEQUEUED;
        r.series    = ring_series[head_slot];
        r.win_begin = ring_day[head_slot];
        r.win_end   = ring_day[head_slot] + WINDOW_SPAN;
        head_slot   = slot_after(head_slot);
        jobs_held   = jobs_held - 1'b1;
      end
    end
    return r;
  endfunction

  task automatic flag_mismatch(string field, logic [63:0] got, logic [63:0] want);
    if (errors < 40)
      $display("%t reply %0d: %s mismatch, got %0h want %0h", $realtime, reply_no, field,
               got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    job_reply_t got;
    job_reply_t want;
    if (!rst_n) begin
      head_slot = '0;
      tail_slot = '0;
      jobs_held = '0;
      pending_replies.delete();
    end else begin
      if (in_tvalid && in_tready)
        pending_replies.push_back(apply_job_request(in_tuser, in_tdata[SERIES_BITS-1:0],
                                    in_tdata[SERIES_BITS+DAY_BITS-1:SERIES_BITS]));
      if (out_tvalid && out_tready) begin
        got.status    = out_tuser;
        got.series    = out_tdata[SERIES_BITS-1:0];
        got.win_begin = out_tdata[SERIES_BITS+DAY_BITS-1:SERIES_BITS];
        got.win_end   = out_tdata[SERIES_BITS+2*DAY_BITS-1:SERIES_BITS+DAY_BITS];
        if (pending_replies.size() == 0) begin
          flag_mismatch("unrequested transfer", {got.win_end, got.win_begin, got.series},
                        '0);
        end else begin
          want = pending_replies.pop_front();
          if (got.status != want.status)
            flag_mismatch("status", 64'(got.status), 64'(want.status));
          if (got.series != want.series)
            flag_mismatch("series", 64'(got.series), 64'(want.series));
          if (got.win_begin != want.win_begin)
            flag_mismatch("window begin", 64'(got.win_begin), 64'(want.win_begin));
          if (got.win_end != want.win_end)
            flag_mismatch("window end", 64'(got.win_end), 64'(want.win_end));
        end
        reply_no++;
      end
    end
    due_count <= pending_replies.size();
  end

endmodule

FILE: verif/tb.sv
`timescale 1ns / 100ps

module tb;
  import djf_pkg::*;

  localparam int RANDOM_JOBS = 700;
  localparam int SEGMENT_LEN = 40;

  typedef enum int {SEG_FILL, SEG_MIXED, SEG_DRAIN} seg_kind_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_DATA_W-1:0]   in_tdata = '0;
  logic                   in_tuser = FUNC_ENQ;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_DATA_W-1:0]  out_tdata;
  logic [STATUS_BITS-1:0] out_tuser;

  int errors;
  int due_count;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  logic [SERIES_BITS-1:0] last_series = '0;
  logic [DAY_BITS-1:0]    last_day = '0;

  // small key pool so duplicates come up often
  logic [SERIES_BITS-1:0] pool_series [4] = '{32'h0, 32'hFFFF_FFFF, 32'h8000_0001, 32'h5A5A_A5A5};
  logic [DAY_BITS-1:0]    pool_day    [4] = '{16'h0, 16'hFFFF, 16'hFFF3, 16'h0007};

  dedup_job_fifo DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  job_fifo_checker u_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .errors     (errors),
    .due_count  (due_count)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // tvalid stays high after a transfer; it only drops when the sender idles or drains replies
  task automatic send_job(logic func, logic [SERIES_BITS-1:0] ser, logic [DAY_BITS-1:0] day);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= func;
    in_tdata  <= {day, ser};
    if (func == FUNC_ENQ) begin
      last_series = ser;
      last_day    = day;
    end
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic drain_replies();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (due_count != 0) @(posedge clk);
  endtask

  task automatic random_job(seg_kind_t kind);
    int                     deq_pct;
    int                     pick;
    logic                   func;
    logic [SERIES_BITS-1:0] ser;
    logic [DAY_BITS-1:0]    day;
    case (kind)
      SEG_FILL:  deq_pct = 10;
      SEG_DRAIN: deq_pct = 85;
      default:   deq_pct = 50;
    endcase
    func = ($urandom_range(0, 99) < deq_pct) ? FUNC_DEQ : FUNC_ENQ;
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      ser = pool_series[$urandom_range(0, 3)];
      day = pool_day[$urandom_range(0, 3)];
    end else if (pick < 40) begin
      ser = last_series;
      day = last_day;
    end else begin
      ser = $urandom;
      day = DAY_BITS'($urandom);
    end
    send_job(func, ser, day);
  endtask

  initial begin
    int n;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty, key extremes, duplicates, day wrap on end window
    send_job(FUNC_DEQ, 32'h1234_5678, 16'h4321);
    send_job(FUNC_ENQ, 32'h0, 16'h0);
    send_job(FUNC_ENQ, 32'h0, 16'h0);
    send_job(FUNC_ENQ, 32'hFFFF_FFFF, 16'hFFFF);
    send_job(FUNC_ENQ, 32'hFFFF_FFFF, 16'h0);
    send_job(FUNC_ENQ, 32'h0, 16'hFFFF);
    send_job(FUNC_ENQ, 32'hFFFF_FFFF, 16'hFFFF);
    send_job(FUNC_ENQ, 32'hAAAA_5555, 16'hFFF3);
    repeat (5) send_job(FUNC_DEQ, 32'hFFFF_FFFF, 16'hFFFF);
    send_job(FUNC_DEQ, 32'h0, 16'h0);
    // dequeued job gone, so the same key is accepted again
    send_job(FUNC_ENQ, 32'h0, 16'h0);
    send_job(FUNC_DEQ, 32'h0, 16'h0);
    drain_replies();

    // idle phases: none, sender, receiver, both
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 79; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 79; end
        default: begin send_idle_pct = 38; recv_stall_pct = 38; end
      endcase
      for (n = 0; n < RANDOM_JOBS / 4; n++)
        random_job(seg_kind_t'((n / SEGMENT_LEN) % 3));
      drain_replies();
    end

    repeat (20) @(posedge clk);
    if (errors == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

FILE: sim.f
hdl/djf_pkg.sv
hdl/djf_ctrl.sv
hdl/djf_dp.sv
hdl/dedup_job_fifo.sv
verif/job_fifo_checker.sv
verif/tb.sv
